[design/tgc_pkg.sv]
// ---------------------------------------------------------------------------
// tgc_pkg
// Shared types, register map and sine table for the touch gesture classifier.
// ---------------------------------------------------------------------------
package tgc_pkg;

    localparam int COORD_BITS = 12;
    localparam int TIME_BITS  = 16;
    localparam int SIN_BITS   = 20;
    localparam int ANG_BITS   = 9;
    localparam int ROT_BITS   = 10;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * COORD_BITS;

    localparam logic [11:0] RING_RESET     = 12'd1200;
    localparam logic [15:0] CIRCLE_RESET   = 16'd50;
    localparam logic [15:0] LONG_TAP_RESET = 16'd200;

    // register index, byte address 4*index
    localparam logic [1:0] REG_RING     = 2'd0;
    localparam logic [1:0] REG_CIRCLE   = 2'd1;
    localparam logic [1:0] REG_LONG_TAP = 2'd2;

    localparam logic [1:0] EV_SHORT_TAP = 2'd0;
    localparam logic [1:0] EV_LONG_TAP  = 2'd1;
    localparam logic [1:0] EV_SWIPE     = 2'd2;
    localparam logic [1:0] EV_CIRCLE    = 2'd3;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    localparam logic [6:0] DEG_90 = 7'd90;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SQUARE  = 6'b000010,
        ST_CLASS   = 6'b000100,
        ST_ANG_MUL = 6'b001000,
        ST_ANG_CMP = 6'b010000,
        ST_FINISH  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        AM_NONE   = 2'd0,
        AM_START  = 2'd1,
        AM_SWIPE  = 2'd2,
        AM_CIRCLE = 2'd3
    } t_ang_mode;

    // sin(d degrees) in millionths
    localparam logic [SIN_BITS-1:0] SIN_TAB [0:90] = '{
        20'd0, 20'd17452, 20'd34899, 20'd52336, 20'd69756, 20'd87156, 20'd104528,
        20'd121869, 20'd139173, 20'd156434, 20'd173648, 20'd190809, 20'd207912,
        20'd224951, 20'd241922, 20'd258819, 20'd275637, 20'd292372, 20'd309017,
        20'd325568, 20'd342020, 20'd358368, 20'd374607, 20'd390731, 20'd406737,
        20'd422618, 20'd438371, 20'd453990, 20'd469472, 20'd484810, 20'd500000,
        20'd515038, 20'd529919, 20'd544639, 20'd559193, 20'd573576, 20'd587785,
        20'd601815, 20'd615661, 20'd629320, 20'd642788, 20'd656059, 20'd669131,
        20'd681998, 20'd694658, 20'd707107, 20'd719340, 20'd731354, 20'd743145,
        20'd754710, 20'd766044, 20'd777146, 20'd788011, 20'd798636, 20'd809017,
        20'd819152, 20'd829038, 20'd838671, 20'd848048, 20'd857167, 20'd866025,
        20'd874620, 20'd882948, 20'd891007, 20'd898794, 20'd906308, 20'd913545,
        20'd920505, 20'd927184, 20'd933580, 20'd939693, 20'd945519, 20'd951057,
        20'd956305, 20'd961262, 20'd965926, 20'd970296, 20'd974370, 20'd978148,
        20'd981627, 20'd984808, 20'd987688, 20'd990268, 20'd992546, 20'd994522,
        20'd996195, 20'd997564, 20'd998630, 20'd999391, 20'd999848, 20'd1000000
    };

endpackage

[design/touch_gesture_classifier.sv]
// ---------------------------------------------------------------------------
// touch_gesture_classifier
// Classifies touchpad polls into taps, four-way swipes and circle rotation.
// ---------------------------------------------------------------------------
// A poll passes the square, classify and finish states, and when an angle is
// needed a binary search of at most 7 steps over a 91-entry sine table, each
// step being a multiply and a compare state. At most one event item per poll;
// the block takes the next poll while an event still waits on the output, but
// if that poll has an event too, it stalls at its end until the slot is free.
module touch_gesture_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_report_valid,
    input  logic signed [tgc_pkg::COORD_BITS-1:0] i_pos_x,
    input  logic signed [tgc_pkg::COORD_BITS-1:0] i_pos_y,
    input  logic [5:0]  i_pressure,
    input  logic [7:0]  i_elapsed_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_event_kind,
    output logic [1:0]  o_swipe_dir,
    output logic signed [tgc_pkg::ROT_BITS-1:0] o_rotation_deg,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CB = tgc_pkg::COORD_BITS;
    localparam int DB = tgc_pkg::DIFF_BITS;
    localparam int TB = tgc_pkg::TIME_BITS;
    localparam int SB = tgc_pkg::SQ_BITS;
    localparam int PB = tgc_pkg::DIFF_BITS + tgc_pkg::SIN_BITS;
    localparam int AB = tgc_pkg::ANG_BITS;
    localparam int RB = tgc_pkg::ROT_BITS;

    // configuration
    logic [11:0] r_ring_radius;
    logic [15:0] r_circle_delay;
    logic [15:0] r_long_tap;

    // gesture state
    logic signed [CB-1:0] r_held_x, r_held_y, r_origin_x, r_origin_y;
    logic [5:0]           r_held_p;
    logic                 r_touching, r_seen_c, r_seen_r, r_circle;
    logic signed [AB-1:0] r_last_angle;
    logic [TB-1:0]        r_touch_time;

    tgc_pkg::t_state    r_state;
    tgc_pkg::t_ang_mode r_mode;

    logic [SB-1:0]   r_sq_x, r_sq_y, r_sq_r;
    logic [DB-1:0]   r_ax, r_ay;
    logic            r_xneg, r_yneg;
    logic [6:0]      r_lo, r_hi, r_mid;
    logic [PB-1:0]   r_pa, r_pb;
    logic            r_need_out;
    logic [1:0]      r_ev_kind;

    logic            cfg_wr;
    logic [TB:0]     tt_sum;
    logic [TB-1:0]   tt_new;
    logic [SB:0]     r2_sum;
    logic            cls_touch, cls_seen_c, cls_seen_r, cls_circle;
    logic signed [DB-1:0] ang_x, ang_y;
    logic [7:0]      mid_sum;
    logic [6:0]      mid;
    logic [6:0]      lo_nx, hi_nx;
    logic [6:0]      ceil_d;
    logic signed [AB-1:0] ang_res;
    logic signed [RB-1:0] delta;
    logic [1:0]      dir;
    logic            out_free;
    logic            out_load;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign out_free = ~o_valid | i_ready;
    assign out_load = (r_state == tgc_pkg::ST_FINISH) & r_need_out & out_free;
    assign o_ready  = (r_state == tgc_pkg::ST_IDLE);

    always_comb begin
        case (paddr[3:2])
            tgc_pkg::REG_RING:     prdata = {20'd0, r_ring_radius};
            tgc_pkg::REG_CIRCLE:   prdata = {16'd0, r_circle_delay};
            tgc_pkg::REG_LONG_TAP: prdata = {16'd0, r_long_tap};
            default:               prdata = 32'd0;
        endcase
    end

    assign tt_sum = {1'b0, r_touch_time} + {{(TB-7){1'b0}}, i_elapsed_ms};
    assign tt_new = tt_sum[TB] ? {TB{1'b1}} : tt_sum[TB-1:0];
    assign r2_sum = {1'b0, r_sq_x} + {1'b0, r_sq_y};

    // classification of the current poll, from registered state
    always_comb begin
        cls_touch  = r_touching;
        cls_seen_c = r_seen_c;
        cls_seen_r = r_seen_r;
        if (r_touching) begin
            if (r_held_p != 6'd0) begin
                if (r2_sum > {1'b0, r_sq_r}) begin
                    cls_seen_r = 1'b1;
                end else begin
                    cls_seen_c = 1'b1;
                end
            end else begin
                cls_touch = 1'b0;
            end
        end
        cls_circle = r_circle |
                     (cls_touch & (r_touch_time > r_circle_delay) & ~cls_seen_c);
    end

    always_comb begin
        if (r_mode == tgc_pkg::AM_SWIPE || !cls_touch) begin
            ang_x = {r_held_x[CB-1], r_held_x} - {r_origin_x[CB-1], r_origin_x};
            ang_y = {r_held_y[CB-1], r_held_y} - {r_origin_y[CB-1], r_origin_y};
        end else begin
            ang_x = {r_held_x[CB-1], r_held_x};
            ang_y = {r_held_y[CB-1], r_held_y};
        end
    end

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi} + 8'd1;
    assign mid     = mid_sum[7:1];
    assign lo_nx   = (r_pa >= r_pb) ? r_mid : r_lo;
    assign hi_nx   = (r_pa >= r_pb) ? r_hi : r_mid - 7'd1;

    always_comb begin
        if (r_ax == '0 || r_ay == '0 || r_ax == r_ay) begin
            ceil_d = r_lo;
        end else begin
            ceil_d = r_lo + 7'd1;
        end
        if (r_ax == '0 && r_ay == '0) begin
            ang_res = '0;
        end else if (!r_yneg) begin
            ang_res = r_xneg ? AB'(9'sd180 - $signed({2'b00, ceil_d}))
                             : $signed({2'b00, r_lo});
        end else begin
            ang_res = r_xneg ? AB'($signed({2'b00, ceil_d}) - 9'sd180)
                             : AB'(-$signed({2'b00, r_lo}));
        end
        delta = RB'($signed({ang_res[AB-1], ang_res}) - $signed({r_last_angle[AB-1],
                                                                  r_last_angle}));
        if (ang_res < -9'sd90) begin
            dir = tgc_pkg::DIR_LEFT;
        end else if (ang_res < 9'sd0) begin
            dir = tgc_pkg::DIR_DOWN;
        end else if (ang_res < 9'sd90) begin
            dir = tgc_pkg::DIR_RIGHT;
        end else begin
            dir = tgc_pkg::DIR_UP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_radius  <= tgc_pkg::RING_RESET;
            r_circle_delay <= tgc_pkg::CIRCLE_RESET;
            r_long_tap     <= tgc_pkg::LONG_TAP_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                tgc_pkg::REG_RING:     r_ring_radius  <= pwdata[11:0];
                tgc_pkg::REG_CIRCLE:   r_circle_delay <= pwdata[15:0];
                tgc_pkg::REG_LONG_TAP: r_long_tap     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tgc_pkg::ST_IDLE;
            r_mode       <= tgc_pkg::AM_NONE;
            r_held_x     <= '0;
            r_held_y     <= '0;
            r_held_p     <= '0;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_touching   <= 1'b0;
            r_seen_c     <= 1'b0;
            r_seen_r     <= 1'b0;
            r_circle     <= 1'b0;
            r_last_angle <= '0;
            r_touch_time <= '0;
            r_need_out   <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            if (o_valid && i_ready && !out_load) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                tgc_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        logic signed [CB-1:0] hx, hy;
                        logic [5:0] hp;
                        hx = i_report_valid ? i_pos_x : r_held_x;
                        hy = i_report_valid ? i_pos_y : r_held_y;
                        hp = i_report_valid ? i_pressure : r_held_p;
                        r_held_x <= hx;
                        r_held_y <= hy;
                        r_held_p <= hp;
                        if (!r_touching && hp != 6'd0) begin
                            // touch start
                            r_touching   <= 1'b1;
                            r_touch_time <= '0;
                            r_circle     <= 1'b0;
                            r_seen_c     <= 1'b0;
                            r_seen_r     <= 1'b0;
                            r_origin_x   <= hx;
                            r_origin_y   <= hy;
                            r_mode       <= tgc_pkg::AM_START;
                        end else begin
                            r_touch_time <= tt_new;
                            r_mode       <= tgc_pkg::AM_NONE;
                        end
                        r_state <= tgc_pkg::ST_SQUARE;
                    end
                end
                tgc_pkg::ST_SQUARE: begin
                    r_sq_x  <= SB'(r_held_x * r_held_x);
                    r_sq_y  <= SB'(r_held_y * r_held_y);
                    r_sq_r  <= SB'(r_ring_radius * r_ring_radius);
                    r_state <= tgc_pkg::ST_CLASS;
                end
                tgc_pkg::ST_CLASS: begin
                    r_touching <= cls_touch;
                    r_seen_c   <= cls_seen_c;
                    r_seen_r   <= cls_seen_r;
                    r_circle   <= cls_circle;
                    r_xneg     <= ang_x < 0;
                    r_yneg     <= ang_y < 0;
                    r_ax       <= ang_x < 0 ? DB'(-ang_x) : DB'(ang_x);
                    r_ay       <= ang_y < 0 ? DB'(-ang_y) : DB'(ang_y);
                    r_lo       <= 7'd0;
                    r_hi       <= tgc_pkg::DEG_90;
                    if (r_mode == tgc_pkg::AM_START) begin
                        // angle only refreshes last_angle
                        r_need_out <= 1'b0;
                        r_state    <= tgc_pkg::ST_ANG_MUL;
                    end else if (r_touching && !cls_touch) begin
                        if (cls_seen_c && !cls_seen_r) begin
                            r_need_out <= 1'b1;
                            r_ev_kind  <= (r_touch_time > r_long_tap) ?
                                          tgc_pkg::EV_LONG_TAP : tgc_pkg::EV_SHORT_TAP;
                            r_state    <= tgc_pkg::ST_FINISH;
                        end else if (cls_seen_c && cls_seen_r) begin
                            r_need_out <= 1'b1;
                            r_ev_kind  <= tgc_pkg::EV_SWIPE;
                            r_mode     <= tgc_pkg::AM_SWIPE;
                            r_state    <= tgc_pkg::ST_ANG_MUL;
                        end else begin
                            r_need_out <= 1'b0;
                            r_state    <= tgc_pkg::ST_FINISH;
                        end
                    end else if (cls_touch && cls_circle) begin
                        r_need_out <= 1'b1;
                        r_ev_kind  <= tgc_pkg::EV_CIRCLE;
                        r_mode     <= tgc_pkg::AM_CIRCLE;
                        r_state    <= tgc_pkg::ST_ANG_MUL;
                    end else begin
                        r_need_out <= 1'b0;
                        r_state    <= tgc_pkg::ST_FINISH;
                    end
                end
                tgc_pkg::ST_ANG_MUL: begin
                    r_mid   <= mid;
                    r_pa    <= PB'(r_ay * tgc_pkg::SIN_TAB[tgc_pkg::DEG_90 - mid]);
                    r_pb    <= PB'(r_ax * tgc_pkg::SIN_TAB[mid]);
                    r_state <= tgc_pkg::ST_ANG_CMP;
                end
                tgc_pkg::ST_ANG_CMP: begin
                    r_lo    <= lo_nx;
                    r_hi    <= hi_nx;
                    r_state <= (lo_nx == hi_nx) ? tgc_pkg::ST_FINISH : tgc_pkg::ST_ANG_MUL;
                end
                tgc_pkg::ST_FINISH: begin
                    if (!r_need_out || out_free) begin
                        if (r_mode == tgc_pkg::AM_START || r_mode == tgc_pkg::AM_CIRCLE) begin
                            r_last_angle <= ang_res;
                        end
                        if (r_need_out) begin
                            o_valid        <= 1'b1;
                            o_event_kind   <= r_ev_kind;
                            o_swipe_dir    <= (r_mode == tgc_pkg::AM_SWIPE) ?
                                              dir : tgc_pkg::DIR_LEFT;
                            o_rotation_deg <= (r_mode == tgc_pkg::AM_CIRCLE) ? delta : '0;
                        end
                        r_state <= tgc_pkg::ST_IDLE;
                    end
                end
                default: r_state <= tgc_pkg::ST_IDLE;
            endcase
        end
    end

endmodule
